### rtl/sfcv_pkg.sv
package sfcv_pkg;

	// payload types
	typedef logic [7:0] byte_t;
	typedef logic [2:0] status_t;
	typedef logic [8:0] count_t;
	typedef logic [15:0] crc_t;

	// configuration port geometry
	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W = 3;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_START_FIRST = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_SECOND = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VERSION = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CMD_MODE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CMD_TYPE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_CMD_SIZE = 3'd5;

	// register reset values
	localparam byte_t RST_START_FIRST = 8'hAA;
	localparam byte_t RST_START_SECOND = 8'h55;
	localparam byte_t RST_VERSION = 8'h01;
	localparam logic RST_CMD_MODE = 1'b0;
	localparam byte_t RST_CMD_TYPE = 8'h01;
	localparam byte_t RST_CMD_SIZE = 8'd16;

	// status codes
	localparam status_t ST_VALID = 3'd0;
	localparam status_t ST_LENGTH = 3'd1;
	localparam status_t ST_START = 3'd2;
	localparam status_t ST_VERSION = 3'd3;
	localparam status_t ST_CRC = 3'd4;
	localparam status_t ST_MSG_TYPE = 3'd5;
	localparam status_t ST_PAYLOAD = 3'd6;

	// frame layout
	localparam count_t POS_START0 = 9'd0;
	localparam count_t POS_START1 = 9'd1;
	localparam count_t POS_VERSION = 9'd2;
	localparam count_t POS_MSG_TYPE = 9'd3;
	localparam count_t POS_LENGTH = 9'd4;
	localparam count_t PAYLOAD_START = 9'd5;
	localparam count_t FRAME_OVERHEAD = 9'd7;
	localparam count_t MIN_FRAME_BYTES = 9'd7;
	localparam count_t COUNT_MAX = 9'd511;

	// crc-16/ccitt-false
	localparam crc_t CRC_POLY = 16'h1021;
	localparam crc_t CRC_INIT = 16'hFFFF;

	// configuration register set
	typedef struct packed {
		byte_t start_first;
		byte_t start_second;
		byte_t version;
		logic  cmd_mode;
		byte_t cmd_type;
		byte_t cmd_size;
	} cfg_t;

	// one byte through the msb-first crc, one bit per step
	function automatic crc_t crc_add_byte(input crc_t crc, input byte_t b);
		crc_t c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### rtl/sfcv_if.sv
// frame byte channel
interface sfcv_in_if;
	logic               valid;
	logic               ready;
	sfcv_pkg::byte_t    frame_byte;
	logic               last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink (input valid, input frame_byte, input last_byte, output ready);
endinterface

// status channel
interface sfcv_out_if;
	logic               valid;
	logic               ready;
	sfcv_pkg::status_t  status;

	modport source (output valid, output status, input ready);
	modport sink (input valid, input status, output ready);
endinterface

### rtl/serial_frame_crc_validator_top.sv
// a last byte passes the input register and then the result register before its status is shown
// throughput: one byte per cycle unless a waiting status stalls a last byte; the crc byte update is combinational
// a waiting status stalls only a later last byte in the input register, and ready drops while it is held
// reset: arst_n asynchronous active low; clears frame state, channel valids
// and restores the configuration registers to their defaults
module serial_frame_crc_validator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sfcv_in_if.sink                              in_ch,
	sfcv_out_if.source                           out_ch,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [sfcv_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [sfcv_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [sfcv_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import sfcv_pkg::*;

	cfg_t    cfg;
	logic    valid_s1;
	byte_t   byte_s1;
	logic    last_s1;
	logic    advance_s1;
	status_t status_n;
	status_t status_q;
	logic    out_valid_q;

	// configuration registers
	assign pready = 1'b1;

	sfcv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (psel && penable && pwrite),
		.wr_idx  (paddr[APB_ADDR_W-1:2]),
		.wr_data (pwdata),
		.rd_data (prdata),
		.cfg     (cfg)
	);

	// input stage moves on unless a status is blocked by a full output
	assign advance_s1 = valid_s1 && (!last_s1 || !out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.frame_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// frame tracking and checks
	sfcv_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.en         (advance_s1),
		.frame_byte (byte_s1),
		.last_byte  (last_s1),
		.status     (status_n)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			status_q <= status_n;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.status = status_q;

endmodule

### rtl/sfcv_regs.sv
module sfcv_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [sfcv_pkg::REG_IDX_W-1:0]       wr_idx,
	input  logic [sfcv_pkg::APB_DATA_W-1:0]      wr_data,
	output logic [sfcv_pkg::APB_DATA_W-1:0]      rd_data,
	output sfcv_pkg::cfg_t                       cfg
);
	import sfcv_pkg::*;

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_first <= RST_START_FIRST;
			cfg_q.start_second <= RST_START_SECOND;
			cfg_q.version <= RST_VERSION;
			cfg_q.cmd_mode <= RST_CMD_MODE;
			cfg_q.cmd_type <= RST_CMD_TYPE;
			cfg_q.cmd_size <= RST_CMD_SIZE;
		end else if (wr_en) begin
			case (wr_idx)
				REG_START_FIRST: cfg_q.start_first <= wr_data[7:0];
				REG_START_SECOND: cfg_q.start_second <= wr_data[7:0];
				REG_VERSION: cfg_q.version <= wr_data[7:0];
				REG_CMD_MODE: cfg_q.cmd_mode <= wr_data[0];
				REG_CMD_TYPE: cfg_q.cmd_type <= wr_data[7:0];
				REG_CMD_SIZE: cfg_q.cmd_size <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (wr_idx)
			REG_START_FIRST: rd_data = {24'd0, cfg_q.start_first};
			REG_START_SECOND: rd_data = {24'd0, cfg_q.start_second};
			REG_VERSION: rd_data = {24'd0, cfg_q.version};
			REG_CMD_MODE: rd_data = {31'd0, cfg_q.cmd_mode};
			REG_CMD_TYPE: rd_data = {24'd0, cfg_q.cmd_type};
			REG_CMD_SIZE: rd_data = {24'd0, cfg_q.cmd_size};
			default: rd_data = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

### rtl/sfcv_frame.sv
module sfcv_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  sfcv_pkg::cfg_t     cfg,
	input  logic               en,
	input  sfcv_pkg::byte_t    frame_byte,
	input  logic               last_byte,
	output sfcv_pkg::status_t  status
);
	import sfcv_pkg::*;

	count_t byte_count_q;
	crc_t   running_crc_q;
	logic   start_mismatch_q;
	logic   version_mismatch_q;
	byte_t  declared_length_q;
	byte_t  message_kind_q;
	crc_t   received_crc_q;

	count_t cnt_n;
	crc_t   crc_n;
	logic   sm_n;
	logic   vm_n;
	byte_t  len_n;
	byte_t  kind_n;
	crc_t   rcrc_n;
	count_t crc_at;
	crc_t   crc_upd;

	assign crc_at = PAYLOAD_START + {1'b0, declared_length_q};
	assign crc_upd = crc_add_byte(running_crc_q, frame_byte);

	// field capture by position in the frame
	always_comb begin
		sm_n = start_mismatch_q;
		vm_n = version_mismatch_q;
		len_n = declared_length_q;
		kind_n = message_kind_q;
		rcrc_n = received_crc_q;
		crc_n = running_crc_q;
		if (byte_count_q == POS_START0) begin
			sm_n = (frame_byte != cfg.start_first);
		end else if (byte_count_q == POS_START1) begin
			if (frame_byte != cfg.start_second) begin
				sm_n = 1'b1;
			end
		end else if (byte_count_q == POS_VERSION) begin
			vm_n = (frame_byte != cfg.version);
			crc_n = crc_upd;
		end else if (byte_count_q == POS_MSG_TYPE) begin
			kind_n = frame_byte;
			crc_n = crc_upd;
		end else if (byte_count_q == POS_LENGTH) begin
			len_n = frame_byte;
			crc_n = crc_upd;
		end else if (byte_count_q < crc_at) begin
			crc_n = crc_upd;
		end else if (byte_count_q == crc_at) begin
			rcrc_n[7:0] = frame_byte;
		end else if (byte_count_q == crc_at + 9'd1) begin
			rcrc_n[15:8] = frame_byte;
		end
		cnt_n = (byte_count_q == COUNT_MAX) ? byte_count_q : byte_count_q + 9'd1;
	end

	// checks in priority order
	always_comb begin
		if (cnt_n < MIN_FRAME_BYTES) begin
			status = ST_LENGTH;
		end else if (sm_n) begin
			status = ST_START;
		end else if (vm_n) begin
			status = ST_VERSION;
		end else if (cnt_n != {1'b0, len_n} + FRAME_OVERHEAD) begin
			status = ST_LENGTH;
		end else if (rcrc_n != crc_n) begin
			status = ST_CRC;
		end else if (cfg.cmd_mode && (kind_n != cfg.cmd_type)) begin
			status = ST_MSG_TYPE;
		end else if (cfg.cmd_mode && (len_n != cfg.cmd_size)) begin
			status = ST_PAYLOAD;
		end else begin
			status = ST_VALID;
		end
	end

	// frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			running_crc_q <= CRC_INIT;
			start_mismatch_q <= 1'b0;
			version_mismatch_q <= 1'b0;
			declared_length_q <= '0;
			message_kind_q <= '0;
			received_crc_q <= '0;
		end else if (en) begin
			if (last_byte) begin
				byte_count_q <= '0;
				running_crc_q <= CRC_INIT;
				start_mismatch_q <= 1'b0;
				version_mismatch_q <= 1'b0;
				declared_length_q <= '0;
				message_kind_q <= '0;
				received_crc_q <= '0;
			end else begin
				byte_count_q <= cnt_n;
				running_crc_q <= crc_n;
				start_mismatch_q <= sm_n;
				version_mismatch_q <= vm_n;
				declared_length_q <= len_n;
				message_kind_q <= kind_n;
				received_crc_q <= rcrc_n;
			end
		end
	end

endmodule

### rtl/sfcv_checker.sv
module sfcv_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               in_last,
	input  logic               out_valid,
	input  logic               out_ready,
	input  sfcv_pkg::status_t  out_status
);
	import sfcv_pkg::*;

	logic [2:0] pending_q;
	logic       in_last_acc;
	logic       out_acc;

	assign in_last_acc = in_valid && in_ready && in_last;
	assign out_acc = out_valid && out_ready;

	// last words accepted whose status is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_last_acc && !out_acc) begin
			pending_q <= pending_q + 3'd1;
		end else if (out_acc && !in_last_acc) begin
			pending_q <= pending_q - 3'd1;
		end
	end

	// a status is held until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("status word dropped while stalled");

	// every status stems from an earlier last word
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("status word without a last byte");

	// at most two frames in flight
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("too many frames in flight");

	// status codes stay in range
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_status <= ST_PAYLOAD)
		else $error("status code out of range");

endmodule

bind serial_frame_crc_validator_top sfcv_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_last    (in_ch.last_byte),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_status (out_ch.status)
);
